/* design/sled_pkg.sv */
package sled_pkg;

  localparam int BUF_BYTES = 64;
  localparam int PTR_W     = $clog2(BUF_BYTES);
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);
  localparam int SUM_W     = ((CNT_W > 8) ? CNT_W : 8) + 2;
  localparam int Q_DEPTH   = 2;
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
  localparam int QIDX_W    = $clog2(Q_DEPTH);

  localparam logic [7:0] START_MARK = 8'h50;
  localparam logic [7:0] END_MARK   = 8'h45;
  localparam logic [1:0] FRAME_OVH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } sled_q_t;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(BUF_BYTES)) begin
      sum = sum - (CNT_W + 1)'(BUF_BYTES);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* design/start_length_end_deframer_unit.sv */
// Start/length/end deframer.
// Input stream: one received serial byte per transfer on in_tdata.
// Output stream: out_tdata is a payload byte (zero for status results),
// out_tuser the kind (0 payload, 1 empty frame, 2 overflow, oldest byte
// dropped), out_tlast marks the final result caused by one input byte.
// A frame is 'P', a length L, L payload bytes and 'E'; it is emitted as one
// run of L payload transfers, or one empty-frame transfer when L is zero,
// and the receive buffer (64 bytes) is then cleared up to the 'E'.
// A two-entry input queue takes bytes while the scan engine works.
// Per byte the engine scans the buffered positions from the oldest one on,
// reads the length and end mark of each 'P' candidate, and emits results
// one at a time. The scan walks the buffer through the single read port of
// its RAM. Bytes ahead of a frame in the buffer delay its first output.
// Reset empties the buffer and the input queue and drops any pending result.
// A stalled receiver holds the output register and, with a result to emit,
// the scan engine; the input queue takes bytes until both entries are full.
module start_length_end_deframer_unit import sled_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [1:0] result_kind
);

  sled_q_t q_head;
  logic    q_pop;

  sled_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  sled_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* design/sled_ram.sv */
module sled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sled_front.sv */
module sled_front import sled_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  output sled_q_t    q_head,
  input  logic       q_pop
);

  logic [7:0]        slot_r [Q_DEPTH];
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic [QCNT_W-1:0] wpos;

  assign in_tready   = (cnt_r < QCNT_W'(Q_DEPTH));
  assign push        = in_tvalid && in_tready;
  assign wpos        = q_pop ? cnt_r - QCNT_W'(1) : cnt_r;
  assign q_head.valid = (cnt_r != '0);
  assign q_head.data  = slot_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
    end
    if (q_pop) begin
      for (int k = 0; k < Q_DEPTH - 1; k++) begin
        slot_r[k] <= slot_r[k+1];
      end
    end
    if (push) begin
      slot_r[wpos[QIDX_W-1:0]] <= in_tdata;
    end
  end

endmodule

/* design/sled_back.sv */
module sled_back import sled_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sled_q_t    q_head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [1:0] out_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_P, S_L, S_E, S_D, S_EMPTY, S_OVF, S_DROP
  } state_t;

  state_t           state_r;
  logic [PTR_W-1:0] head_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] i_r;
  logic [7:0]       len_r;
  logic [7:0]       j_r;
  logic [SUM_W-1:0] end_r;
  logic             drop_r;
  logic             ovalid_r;
  logic [7:0]       obyte_r;
  logic             olast_r;
  kind_t            okind_r;

  logic             full;
  logic             out_free;
  logic             emit;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] raddr;
  logic [7:0]       rdata;
  logic [SUM_W-1:0] end_nxt;
  logic [CNT_W-1:0] pay_off;
  logic             pay_last;

  assign full     = (cnt_r == CNT_W'(BUF_BYTES));
  assign out_free = !ovalid_r || out_tready;
  assign emit     = out_free &&
                    (state_r == S_D || state_r == S_EMPTY || state_r == S_OVF);
  assign q_pop    = (state_r == S_IDLE) && q_head.valid;
  assign we       = q_pop;
  assign waddr    = full ? head_r : wrap_add(head_r, cnt_r);
  assign end_nxt  = SUM_W'(i_r) + SUM_W'(rdata) + SUM_W'(FRAME_OVH);
  assign pay_off  = i_r + CNT_W'(FRAME_OVH) + CNT_W'(j_r);
  assign pay_last = ({1'b0, j_r} + 9'd1) == {1'b0, len_r};

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = okind_r;

  always_comb begin
    case (state_r)
      S_SCAN:  raddr = wrap_add(head_r, i_r);
      S_P:     raddr = wrap_add(head_r, i_r + CNT_W'(1));
      S_L:     raddr = wrap_add(head_r, end_nxt[CNT_W-1:0]);
      S_E:     raddr = wrap_add(head_r, i_r + CNT_W'(FRAME_OVH));
      S_D:     raddr = wrap_add(head_r, out_free ? pay_off + CNT_W'(1) : pay_off);
      default: raddr = '0;
    endcase
  end

  sled_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_head.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (emit) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_head.valid) begin
            if (full) begin
              head_r <= wrap_add(head_r, CNT_W'(1));
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
            drop_r  <= full;
            i_r     <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (i_r + CNT_W'(1) < cnt_r) begin
            state_r <= S_P;
          end else begin
            state_r <= drop_r ? S_OVF : S_IDLE;
          end
        end
        S_P: begin
          if (rdata == START_MARK) begin
            state_r <= S_L;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_SCAN;
          end
        end
        S_L: begin
          len_r <= rdata;
          end_r <= end_nxt;
          if (end_nxt < SUM_W'(cnt_r)) begin
            state_r <= S_E;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_SCAN;
          end
        end
        S_E: begin
          j_r <= '0;
          if (rdata == END_MARK) begin
            state_r <= (len_r == 8'd0) ? S_EMPTY : S_D;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_SCAN;
          end
        end
        S_D: begin
          if (out_free) begin
            obyte_r  <= rdata;
            olast_r  <= pay_last;
            okind_r  <= KIND_PAYLOAD;
            j_r      <= j_r + 8'd1;
            if (pay_last) begin
              state_r <= S_DROP;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            obyte_r  <= 8'd0;
            olast_r  <= 1'b1;
            okind_r  <= KIND_EMPTY;
            state_r  <= S_DROP;
          end
        end
        S_OVF: begin
          if (out_free) begin
            obyte_r  <= 8'd0;
            olast_r  <= 1'b1;
            okind_r  <= KIND_OVERFLOW;
            state_r  <= S_IDLE;
          end
        end
        S_DROP: begin
          head_r  <= wrap_add(head_r, end_r[CNT_W-1:0] + CNT_W'(1));
          cnt_r   <= cnt_r - end_r[CNT_W-1:0] - CNT_W'(1);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/sled_chk.sv */
module sled_chk import sled_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined result kind");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PAYLOAD |-> out_tlast && out_tdata == 8'd0)
    else $error("status result not single and zero");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind start_length_end_deframer_unit sled_chk u_sled_chk (.*);

/* test/tb_start_length_end_deframer_unit.sv */
module tb_start_length_end_deframer_unit import sled_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
  } frame_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  logic [7:0]    rx_pending[$];
  frame_result_t result_expected[$];
  logic [7:0]    rx_window[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_cycles;
  int  mismatch_count;
  int  cycle_count;

  start_length_end_deframer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] rx_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] payload_byte
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)   // [1:0] result_kind
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic frame_result_t make_result(logic [7:0] d, logic l, kind_t k);
    frame_result_t r;
    r.data = d;
    r.last = l;
    r.kind = k;
    return r;
  endfunction

  // append one byte to the receive window, then search for a frame ending at it
  task automatic deframe_byte(input logic [7:0] rx);
    bit dropped;
    int len;
    int stop;
    dropped = 1'b0;
    if (rx_window.size() == BUF_BYTES) begin
      void'(rx_window.pop_front());
      dropped = 1'b1;
    end
    rx_window.push_back(rx);
    for (int i = 0; i + 1 < rx_window.size(); i++) begin
      if (rx_window[i] == START_MARK) begin
        len  = rx_window[i + 1];
        stop = i + len + FRAME_OVH;
        if (stop < rx_window.size() && rx_window[stop] == END_MARK) begin
          if (len == 0) begin
            result_expected.push_back(make_result(8'd0, 1'b1, KIND_EMPTY));
          end else begin
            for (int j = 0; j < len; j++) begin
              result_expected.push_back(make_result(rx_window[i + 2 + j],
                                                    j + 1 == len, KIND_PAYLOAD));
            end
          end
          for (int j = 0; j <= stop; j++) begin
            void'(rx_window.pop_front());
          end
          return;
        end
      end
    end
    if (dropped) begin
      result_expected.push_back(make_result(8'd0, 1'b1, KIND_OVERFLOW));
    end
  endtask

  task automatic queue_frame(input int len);
    rx_pending.push_back(START_MARK);
    rx_pending.push_back(len[7:0]);
    for (int j = 0; j < len; j++) begin
      rx_pending.push_back(8'($urandom_range(0, 255)));
    end
    rx_pending.push_back(END_MARK);
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_tvalid || result_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_pending.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      deframe_byte(in_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready      <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_expected.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
          $display("unexpected transfer: data %h last %b kind %0d",
                   out_tdata, out_tlast, out_tuser);
        end
      end else begin
        want = result_expected.pop_front();
        if (out_tdata !== want.data || out_tlast !== want.last
            || out_tuser !== want.kind) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected data %h last %b kind %0d, got %h %b %0d",
                     want.data, want.last, want.kind, out_tdata, out_tlast, out_tuser);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int sel;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = 8'd0;
    out_tready      = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    queue_frame(0);
    queue_frame(3);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(START_MARK);
    rx_pending.push_back(8'd200);
    queue_frame(1);
    rx_pending.push_back(8'h00);
    wait_drained();

    // fill to overflow, then long frame of max length in full buffer
    for (int i = 0; i < 70; i++) begin
      rx_pending.push_back(8'($urandom_range(0, 255)) & 8'h3F);
    end
    queue_frame(61);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 61 : 23) : 0;
      recv_stall_pct = (phase == 2) ? 61 : ((phase == 3) ? 23 : 0);
      if (phase == 2) begin
        hold_off_cycles = 2000;
      end
      while (rx_pending.size() < 80) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          queue_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, 61)
                                                   : $urandom_range(0, 6));
        end else if (sel < 8) begin
          rx_pending.push_back(8'($urandom_range(0, 255)));
        end else begin
          rx_pending.push_back(START_MARK);
          rx_pending.push_back(8'($urandom_range(0, 255)));
          rx_pending.push_back($urandom_range(0, 1) ? END_MARK : 8'hAA);
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/sled_pkg.sv
design/sled_ram.sv
design/sled_front.sv
design/sled_back.sv
design/start_length_end_deframer_unit.sv
design/sled_chk.sv
test/tb_start_length_end_deframer_unit.sv
